// ----- rtl/voxel_ray_traversal_core_assert.svh -----
// Assertion macros for the voxel ray traversal core.
// Included by the RTL file that checks its own control logic.
`ifndef VOXEL_RAY_TRAVERSAL_CORE_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define VRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voxel ray traversal check failed");

// Condition implies consequence in the next cycle.
`define VRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voxel ray traversal check failed");

`endif

// ----- rtl/voxrt_pkg.sv -----
// Shared types and constants for the voxel ray traversal core.
// No dependencies.
`default_nettype none
package voxrt_pkg;
    localparam int GRID_X_DEF = 64;
    localparam int GRID_Y_DEF = 64;
    localparam int GRID_Z_DEF = 64;

    localparam int POS_W    = 18;
    localparam int DIR_W    = 16;
    localparam int RANGE_W  = 18;
    localparam int VOX_W    = 6;
    localparam int CELL_W   = 12;
    localparam int TIME_W   = 32;
    localparam int DVD_W    = 31;
    localparam int FRAC_SH  = 22;
    localparam int NUM_W    = 9;

    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 18'd16384;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RST = 18'd0;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    localparam logic CFG_MAX_RANGE = 1'b0;
    localparam logic CFG_MIN_RANGE = 1'b1;

    typedef struct packed {
        logic              go;
        logic [DVD_W-1:0]  dividend;
        logic [DIR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- rtl/voxrt_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module voxrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/voxrt_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on voxrt_pkg.
`default_nettype none
module voxrt_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire voxrt_pkg::t_div_req i_req,
    output voxrt_pkg::t_div_rsp     o_rsp
);
    localparam int DW  = voxrt_pkg::DVD_W;
    localparam int SW  = voxrt_pkg::DIR_W;
    localparam int CW  = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_dvs;
    logic [DW-1:0] r_quo;
    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          qbit;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[SW-1:0] : trial[SW-1:0];
            r_quo <= {r_quo[DW-2:0], qbit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// ----- rtl/voxel_ray_traversal_core.sv -----
// Voxel ray traversal: occupancy grid writes and 3D DDA ray casts.
// Operation: a write takes effect at its accept edge and gives no result. A cast takes
// up to 6 serial divisions on one shared divider, then per visited voxel a limit test,
// a grid read (in-grid voxels only) and a boundary step; one result strobe.
// After reset a clearing pass over all GRID_X*GRID_Y*GRID_Z cells zeroes the grid RAM, busy
// stays high meanwhile. The result strobe lasts one cycle and cannot be stalled.
`default_nettype none
module voxel_ray_traversal_core #(
    parameter int GRID_X = voxrt_pkg::GRID_X_DEF,
    parameter int GRID_Y = voxrt_pkg::GRID_Y_DEF,
    parameter int GRID_Z = voxrt_pkg::GRID_Z_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_action,
    input  wire logic [voxrt_pkg::VOX_W-1:0]    i_voxel_x,
    input  wire logic [voxrt_pkg::VOX_W-1:0]    i_voxel_y,
    input  wire logic [voxrt_pkg::VOX_W-1:0]    i_voxel_z,
    input  wire logic                           i_occupied,
    input  wire logic signed [voxrt_pkg::POS_W-1:0] i_start_x,
    input  wire logic signed [voxrt_pkg::POS_W-1:0] i_start_y,
    input  wire logic signed [voxrt_pkg::POS_W-1:0] i_start_z,
    input  wire logic signed [voxrt_pkg::DIR_W-1:0] i_dir_x,
    input  wire logic signed [voxrt_pkg::DIR_W-1:0] i_dir_y,
    input  wire logic signed [voxrt_pkg::DIR_W-1:0] i_dir_z,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [voxrt_pkg::RANGE_W-1:0]  i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_hit,
    output logic [voxrt_pkg::RANGE_W-1:0]       o_distance
);
`include "voxel_ray_traversal_core_assert.svh"

    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int IW    = $clog2(CELLS);
    localparam int CW    = voxrt_pkg::CELL_W;
    localparam int TW    = voxrt_pkg::TIME_W;
    localparam int DW    = voxrt_pkg::DIR_W;
    localparam int RW    = voxrt_pkg::RANGE_W;
    localparam int NW    = voxrt_pkg::NUM_W;
    localparam int QW    = voxrt_pkg::DVD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_DIV_WAIT, S_TEST, S_READ, S_STEP
    } t_state;

    t_state          r_state;
    logic            r_clearing;
    logic [IW-1:0]   r_clr_addr;
    logic [RW-1:0]   r_max_range;
    logic [RW-1:0]   r_min_range;
    logic [2:0]      r_div_idx;
    logic [TW-1:0]   r_t;
    logic signed [CW-1:0] r_cell  [3];
    logic [TW-1:0]   r_next  [3];
    logic [TW-1:0]   r_delta [3];
    logic [DW-1:0]   r_ad    [3];
    logic [NW-1:0]   r_num   [3];
    logic [2:0]      r_neg;
    logic [2:0]      r_moves;
    logic            r_strobe;
    logic            r_hit;
    logic [RW-1:0]   r_dist;

    voxrt_pkg::t_div_req div_req;
    voxrt_pkg::t_div_rsp div_rsp;

    logic            accept;
    logic            wr_in_grid;
    logic [IW-1:0]   wr_index;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic            ram_wdata;
    logic            ram_rdata;
    logic            walk_in_grid;
    logic [IW-1:0]   walk_index;
    logic [1:0]      div_axis;
    logic            div_kind;
    logic            x_first;
    logic            y_first;
    logic [1:0]      sel;
    logic            t_below_max;
    logic            t_below_min;
    logic signed [DW-1:0] dirs   [3];
    logic signed [voxrt_pkg::POS_W-1:0] starts [3];

    assign accept = start && !busy;
    assign busy   = r_clearing || (r_state != S_IDLE);

    assign dirs[0]   = i_dir_x;
    assign dirs[1]   = i_dir_y;
    assign dirs[2]   = i_dir_z;
    assign starts[0] = i_start_x;
    assign starts[1] = i_start_y;
    assign starts[2] = i_start_z;

    always_comb begin
        wr_in_grid = (CW'(i_voxel_x) < CW'(GRID_X)) && (CW'(i_voxel_y) < CW'(GRID_Y))
                  && (CW'(i_voxel_z) < CW'(GRID_Z));
        wr_index   = IW'((IW'(i_voxel_z) * IW'(GRID_Y) + IW'(i_voxel_y)) * IW'(GRID_X)
                  + IW'(i_voxel_x));
        walk_in_grid = (r_cell[0] >= 0) && (r_cell[0] < CW'(GRID_X))
                    && (r_cell[1] >= 0) && (r_cell[1] < CW'(GRID_Y))
                    && (r_cell[2] >= 0) && (r_cell[2] < CW'(GRID_Z));
        walk_index = IW'((IW'(r_cell[2]) * IW'(GRID_Y) + IW'(r_cell[1])) * IW'(GRID_X)
                  + IW'(r_cell[0]));
    end

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = accept && (i_action == voxrt_pkg::ACT_WRITE) && wr_in_grid;
            ram_waddr = wr_index;
            ram_wdata = i_occupied;
        end
    end

    voxrt_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (walk_index),
        .o_rdata (ram_rdata)
    );

    // odd slots compute the first crossing, even slots the step time
    assign div_axis = r_div_idx[2:1];
    assign div_kind = r_div_idx[0];

    always_comb begin
        div_req.go       = (r_state == S_DIV) && (r_div_idx != 3'd6) && r_moves[div_axis];
        div_req.dividend = div_kind ? QW'({r_num[div_axis], {voxrt_pkg::FRAC_SH{1'b0}}})
                                    : QW'(1 << 30);
        div_req.divisor  = r_ad[div_axis];
    end

    voxrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // tie order: x only if strictly first, then y if strictly before z, else z
    always_comb begin
        x_first = r_moves[0] && (!r_moves[1] || r_next[0] < r_next[1])
               && (!r_moves[2] || r_next[0] < r_next[2]);
        y_first = r_moves[1] && (!r_moves[2] || r_next[1] < r_next[2]);
        sel     = x_first ? 2'd0 : (y_first ? 2'd1 : 2'd2);
        t_below_max = r_t < TW'({r_max_range, 8'd0});
        t_below_min = r_t < TW'({r_min_range, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_max_range <= voxrt_pkg::MAX_RANGE_RST;
            r_min_range <= voxrt_pkg::MIN_RANGE_RST;
            r_strobe    <= 1'b0;
            r_div_idx   <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(CELLS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    voxrt_pkg::CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                    voxrt_pkg::CFG_MIN_RANGE: r_min_range <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_action == voxrt_pkg::ACT_CAST)) begin
                        for (int a = 0; a < 3; a++) begin
                            // floor of the origin, sign kept
                            r_cell[a]  <= CW'(starts[a] >>> 8);
                            r_neg[a]   <= dirs[a] < 0;
                            r_moves[a] <= dirs[a] != 0;
                            r_ad[a]    <= (dirs[a] < 0) ? DW'(-dirs[a]) : DW'(dirs[a]);
                            r_num[a]   <= (dirs[a] < 0) ? NW'(starts[a][7:0])
                                        : NW'(9'd256 - NW'(starts[a][7:0]));
                        end
                        r_div_idx <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_div_idx == 3'd6) begin
                        r_t     <= '0;
                        r_state <= S_TEST;
                    end else if (r_moves[div_axis]) begin
                        r_state <= S_DIV_WAIT;
                    end else begin
                        r_next[div_axis]  <= '0;
                        r_delta[div_axis] <= '0;
                        r_div_idx <= r_div_idx + 1'b1;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_kind) begin
                            r_next[div_axis] <= TW'(div_rsp.quotient);
                        end else begin
                            r_delta[div_axis] <= TW'(div_rsp.quotient);
                        end
                        r_div_idx <= r_div_idx + 1'b1;
                        r_state   <= S_DIV;
                    end
                end
                S_TEST: begin
                    if (!t_below_max) begin
                        r_hit    <= 1'b0;
                        r_dist   <= '0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if (walk_in_grid) begin
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_READ: begin
                    if (ram_rdata) begin
                        r_hit    <= 1'b1;
                        r_dist   <= t_below_min ? '0 : r_t[RW+7:8];
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (!r_moves[sel]) begin
                        r_hit    <= 1'b0;
                        r_dist   <= '0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cell[sel] <= r_neg[sel] ? r_cell[sel] - 1'b1 : r_cell[sel] + 1'b1;
                        r_t         <= r_next[sel];
                        r_next[sel] <= r_next[sel] + r_delta[sel];
                        r_state     <= S_TEST;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe   = r_strobe;
    assign o_hit      = r_hit;
    assign o_distance = r_dist;

    `VRT_ASSERT_SAME(a_clear_busy, i_clk, i_rst_n, r_clearing, busy)
    `VRT_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_strobe && !o_hit, o_distance == '0)
    `VRT_ASSERT_SAME(a_dist_range, i_clk, i_rst_n, o_strobe, o_distance <= r_max_range)
    `VRT_ASSERT_NEXT(a_strobe_end, i_clk, i_rst_n, r_state == S_DIV_WAIT, !o_strobe)
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for voxel_ray_traversal_core: directed table, then random grid writes and ray casts.
// Expected hit and distance: table values where given, else a DDA walk over a local grid copy.
// Depends on rtl/voxrt_pkg.sv and rtl/voxel_ray_traversal_core.sv.
`timescale 1ns / 1ps
module tb;
    import voxrt_pkg::*;

    localparam int NVOX = GRID_X_DEF * GRID_Y_DEF * GRID_Z_DEF;

    typedef struct {
        logic                      act;
        logic [VOX_W-1:0]          vx, vy, vz;
        logic                      occ;
        logic signed [POS_W-1:0]   sx, sy, sz;
        logic signed [DIR_W-1:0]   dx, dy, dz;
    } ray_req_t;

    typedef struct {
        bit                    hit;
        logic [RANGE_W-1:0]    distance;
    } ray_hit_t;

    typedef struct {
        ray_req_t  req;
        bit        typed;
        ray_hit_t  want;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_action = ACT_WRITE;
    logic [VOX_W-1:0] i_voxel_x = '0, i_voxel_y = '0, i_voxel_z = '0;
    logic i_occupied = 1'b0;
    logic signed [POS_W-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [DIR_W-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = CFG_MAX_RANGE;
    logic [RANGE_W-1:0] i_cfg_data = '0;
    logic o_strobe;
    logic o_hit;
    logic [RANGE_W-1:0] o_distance;

    bit vox_occ [NVOX];
    logic [RANGE_W-1:0] max_rng = MAX_RANGE_RST;
    logic [RANGE_W-1:0] min_rng = MIN_RANGE_RST;
    ray_hit_t pending_hits[$];
    dir_row_t rows[$];
    int mismatches = 0;

    voxel_ray_traversal_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_voxel_x(i_voxel_x), .i_voxel_y(i_voxel_y),
        .i_voxel_z(i_voxel_z), .i_occupied(i_occupied),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_start_z(i_start_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_hit(o_hit), .o_distance(o_distance)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Walk voxel boundaries in order of crossing time (Q.16) until a hit, max range or no motion.
    function automatic ray_hit_t trace_ray(ray_req_t r);
        ray_hit_t res;
        logic signed [POS_W-1:0] org[3];
        logic signed [DIR_W-1:0] dv[3];
        int cur[3], stp[3];
        bit mv[3];
        longint unsigned nxt[3], dlt[3], frac, ad, t, lim;
        logic [POS_W-1:0] u;
        int s;
        res.hit = 0;
        res.distance = '0;
        org = '{r.sx, r.sy, r.sz};
        dv = '{r.dx, r.dy, r.dz};
        for (int a = 0; a < 3; a++) begin
            u = org[a] ^ 18'h20000;
            frac = u[7:0];
            cur[a] = int'(u[17:8]) - 512;
            stp[a] = (dv[a] > 0) ? 1 : -1;
            mv[a] = dv[a] != 0;
            ad = (dv[a] < 0) ? longint'(-int'(dv[a])) : longint'(dv[a]);
            nxt[a] = 0;
            dlt[a] = 0;
            if (mv[a]) begin
                dlt[a] = (64'd1 << 30) / ad;
                nxt[a] = (dv[a] > 0) ? ((256 - frac) << 22) / ad : (frac << 22) / ad;
            end
        end
        lim = longint'(max_rng) << 8;
        t = 0;
        while (t < lim) begin
            if (cur[0] >= 0 && cur[0] < GRID_X_DEF && cur[1] >= 0 && cur[1] < GRID_Y_DEF &&
                cur[2] >= 0 && cur[2] < GRID_Z_DEF &&
                vox_occ[(cur[2] * GRID_Y_DEF + cur[1]) * GRID_X_DEF + cur[0]]) begin
                res.hit = 1;
                res.distance = (t < (longint'(min_rng) << 8)) ? '0 : RANGE_W'(t >> 8);
                return res;
            end
            // x only when strictly first, then y when strictly before z
            if (mv[0] && (!mv[1] || nxt[0] < nxt[1]) && (!mv[2] || nxt[0] < nxt[2]))
                s = 0;
            else if (mv[1] && (!mv[2] || nxt[1] < nxt[2]))
                s = 1;
            else
                s = 2;
            if (!mv[s])
                break;
            cur[s] += stp[s];
            t = nxt[s];
            nxt[s] += dlt[s];
        end
        return res;
    endfunction

    function automatic ray_req_t mk_write(int x, int y, int z, bit occ);
        ray_req_t r = '{default: '0};
        r.act = ACT_WRITE;
        r.vx = VOX_W'(x);
        r.vy = VOX_W'(y);
        r.vz = VOX_W'(z);
        r.occ = occ;
        return r;
    endfunction

    function automatic ray_req_t mk_cast(int sx, int sy, int sz, int dx, int dy, int dz);
        ray_req_t r = '{default: '0};
        r.act = ACT_CAST;
        r.sx = POS_W'(sx);
        r.sy = POS_W'(sy);
        r.sz = POS_W'(sz);
        r.dx = DIR_W'(dx);
        r.dy = DIR_W'(dy);
        r.dz = DIR_W'(dz);
        return r;
    endfunction

    function automatic void add_row(ray_req_t req, bit typed, ray_hit_t want);
        dir_row_t row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        rows.insert(rows.size(), row);
    endfunction

    function automatic int rand_dir();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k == 1) return $urandom_range(1) ? 16384 : -16384;
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic int rand_org();
        int k;
        k = $urandom_range(9);
        if (k < 6) return $urandom_range(16383);
        if (k < 9) return $urandom_range(12287, 4096);
        return int'($urandom_range(262143)) - 131072;
    endfunction

    function automatic ray_req_t rand_req();
        if ($urandom_range(1))
            return mk_cast(rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(), rand_dir());
        // keep most writes in a central block so casts find something to hit
        if ($urandom_range(9) < 6)
            return mk_write($urandom_range(39, 24), $urandom_range(39, 24),
                            $urandom_range(39, 24), $urandom_range(9) < 8);
        return mk_write($urandom_range(63), $urandom_range(63), $urandom_range(63),
                        $urandom_range(1) == 1);
    endfunction

    // Present one request, hold until accepted, then update the grid copy or queue a result.
    task automatic issue(ray_req_t r, int idle_pct, bit typed, ray_hit_t want);
        int gap;
        gap = (int'($urandom_range(99)) < idle_pct) ? $urandom_range(4, 1) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = r.act;
        i_voxel_x = r.vx;
        i_voxel_y = r.vy;
        i_voxel_z = r.vz;
        i_occupied = r.occ;
        i_start_x = r.sx;
        i_start_y = r.sy;
        i_start_z = r.sz;
        i_dir_x = r.dx;
        i_dir_y = r.dy;
        i_dir_z = r.dz;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        if (r.act == ACT_WRITE)
            vox_occ[(int'(r.vz) * GRID_Y_DEF + int'(r.vy)) * GRID_X_DEF + int'(r.vx)] = r.occ;
        else
            pending_hits.insert(pending_hits.size(), typed ? want : trace_ray(r));
    endtask

    // Drain outstanding casts, then write one range register.
    task automatic write_range(logic idx, logic [RANGE_W-1:0] val);
        @(negedge i_clk);
        start = 1'b0;
        wait (pending_hits.size() == 0);
        repeat (8) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_MAX_RANGE)
            max_rng = val;
        else
            min_rng = val;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0d distance=%0d", o_hit, o_distance);
            end else begin
                ray_hit_t e;
                e = pending_hits.pop_front();
                if (o_hit !== e.hit || o_distance !== e.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                                 e.hit, e.distance, o_hit, o_distance);
                end
            end
        end
    end

    initial begin
        ray_hit_t no_hit, w;
        ray_hit_t none;
        int phase_max[6] = '{16384, 4096, 0, 262143, 20000, 8192};
        int phase_min[6] = '{0, 512, 0, 262143, 2048, 0};
        int phase_idle[6] = '{0, 51, 0, 25, 25, 51};
        int phase_n[6] = '{400, 400, 40, 30, 400, 160};

        no_hit = '{0, '0};
        none = '{0, '0};
        add_row(mk_cast(8192, 8192, 8192, 16384, 0, 0), 1, no_hit);
        add_row(mk_write(40, 32, 32, 1), 0, none);
        w = '{1, 18'd2048};
        add_row(mk_cast(8192, 8192, 8192, 16384, 0, 0), 1, w);
        // negative direction from a boundary crosses at time zero
        w = '{1, 18'd1792};
        add_row(mk_cast(12288, 8192, 8192, -16384, 0, 0), 1, w);
        w = '{1, 18'd0};
        add_row(mk_cast(10240, 8192, 8192, 0, 0, 0), 1, w);
        add_row(mk_cast(2000, 2000, 2000, 0, 0, 0), 1, no_hit);
        add_row(mk_cast(5000, 8192, 8192, 11585, 11585, 0), 0, none);
        add_row(mk_cast(6000, 6000, 6000, 9459, 9459, 9459), 0, none);
        add_row(mk_cast(8200, 8250, 8192, 16384, 1, -1), 0, none);
        add_row(mk_write(63, 63, 63, 1), 0, none);
        add_row(mk_write(0, 0, 0, 1), 0, none);
        // origin outside the grid, walk skips until voxel 0
        w = '{1, 18'd2688};
        add_row(mk_cast(-2688, 128, 128, 16384, 0, 0), 1, w);
        add_row(mk_cast(131071, 131071, 131071, -16384, -16384, -16384), 0, none);
        add_row(mk_cast(-131072, -131072, -131072, 16384, 16384, 16384), 0, none);
        add_row(mk_cast(16383, 16383, 16383, -16384, -16384, -16384), 0, none);
        add_row(mk_cast(16200, 16200, 16200, 3, 7, -5), 0, none);
        add_row(mk_write(40, 32, 32, 0), 0, none);
        add_row(mk_cast(8192, 8192, 8192, 16384, 0, 0), 1, no_hit);
        add_row(mk_cast(100, 100, 100, -16384, -16384, -16384), 0, none);
        add_row(mk_cast(-300, -300, -300, 16384, 16384, 16384), 0, none);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i])
            issue(rows[i].req, 0, rows[i].typed, rows[i].want);

        for (int p = 0; p < 6; p++) begin
            write_range(CFG_MAX_RANGE, RANGE_W'(phase_max[p]));
            write_range(CFG_MIN_RANGE, RANGE_W'(phase_min[p]));
            for (int n = 0; n < phase_n[p]; n++)
                issue(rand_req(), phase_idle[p], 0, none);
        end

        @(negedge i_clk);
        start = 1'b0;
        wait (pending_hits.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
